FILE: src/ptfh_pkg.sv
// Shared types, widths, codes and register defaults for the proximity handshake controller.
package ptfh_pkg;

	// field widths
	localparam int CMD_W    = 2;
	localparam int ECHO_W   = 16;
	localparam int BYTE_W   = 8;
	localparam int LAMP_W   = 4;
	localparam int TIME_W   = 16;
	localparam int THRESH_W = 10;
	localparam int TPC_W    = 8;
	localparam int IDX_W    = 3;
	localparam int CFG_W    = 16;

	// stream payload widths, rounded up to whole bytes
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 16;

	localparam int COUNT_WIDTH_DEF = 16;

	// item kinds
	localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ECHO = 2'd1;
	localparam logic [CMD_W-1:0] CMD_BYTE = 2'd2;

	// frame and status bytes
	localparam logic [BYTE_W-1:0] BYTE_HEAD = 8'hAA;
	localparam logic [BYTE_W-1:0] BYTE_TAIL = 8'h55;
	localparam logic [BYTE_W-1:0] TX_READY  = 8'hA1;
	localparam logic [BYTE_W-1:0] TX_ACK    = 8'hCC;
	localparam logic [BYTE_W-1:0] TX_DONE   = 8'hDD;
	localparam logic [BYTE_W-1:0] TX_ERROR  = 8'hEE;

	// valid class codes
	localparam logic [BYTE_W-1:0] CLASS_MIN = 8'd1;
	localparam logic [BYTE_W-1:0] CLASS_MAX = 8'd4;

	// register indexes
	localparam logic [IDX_W-1:0] REG_THRESH     = 3'd0;
	localparam logic [IDX_W-1:0] REG_TICKS_CM   = 3'd1;
	localparam logic [IDX_W-1:0] REG_HEAD_WAIT  = 3'd2;
	localparam logic [IDX_W-1:0] REG_BYTE_WAIT  = 3'd3;
	localparam logic [IDX_W-1:0] REG_CLASS_SHOW = 3'd4;
	localparam logic [IDX_W-1:0] REG_COOLDOWN   = 3'd5;
	localparam logic [IDX_W-1:0] REG_BLINK_WAIT = 3'd6;

	// register reset values
	localparam logic [THRESH_W-1:0] THRESH_RST     = 10'd15;
	localparam logic [TPC_W-1:0]    TICKS_CM_RST   = 8'd54;
	localparam logic [TIME_W-1:0]   HEAD_WAIT_RST  = 16'd10000;
	localparam logic [TIME_W-1:0]   BYTE_WAIT_RST  = 16'd1000;
	localparam logic [TIME_W-1:0]   CLASS_SHOW_RST = 16'd3000;
	localparam logic [TIME_W-1:0]   COOLDOWN_RST   = 16'd2550;
	localparam logic [TIME_W-1:0]   BLINK_WAIT_RST = 16'd350;

	typedef struct packed {
		logic [THRESH_W-1:0] detect_threshold_cm;
		logic [TPC_W-1:0]    ticks_per_cm;
		logic [TIME_W-1:0]   head_wait_ms;
		logic [TIME_W-1:0]   byte_wait_ms;
		logic [TIME_W-1:0]   class_show_ms;
		logic [TIME_W-1:0]   cooldown_ms;
		logic [TIME_W-1:0]   blink_wait_ms;
	} cfg_t;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [ECHO_W-1:0] echo_count;
		logic              echo_missing;
		logic [BYTE_W-1:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic              tx_valid;
		logic [BYTE_W-1:0] tx_byte;
		logic [LAMP_W-1:0] class_lamps;
		logic              detect_lamp;
		logic              want_measure;
	} res_t;

endpackage

FILE: src/proximity_triggered_frame_handshake.sv
// Top level: config registers, input beat register, output register and stream handshake.
// Path: an accepted input beat is held in the input beat register, then its result in the result register (two-stage).
// Throughput: one beat per cycle; the input register drains into the result register
// whenever the result register is empty or its beat is taken in the same cycle.
// Every step is one short update of the phase/countdown state (one 11x8 multiply and a
// 19-bit compare set the deepest path); each input beat yields exactly one result beat.
// Reset (arst_n low, asynchronous): idle, lamps off, countdown zero, registers at defaults.
module proximity_triggered_frame_handshake #(
	parameter int COUNT_WIDTH = ptfh_pkg::COUNT_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// input stream
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// [15:0] echo_count, [16] echo_missing, [24:17] rx_byte, [31:25] zero
	input  logic [ptfh_pkg::IN_TDATA_W-1:0]    s_tdata,
	// [1:0] command
	input  logic [ptfh_pkg::CMD_W-1:0]         s_tuser,
	// result stream
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [7:0] tx_byte, [11:8] class_lamps, [12] detect_lamp, [13] want_measure, [15:14] zero
	output logic [ptfh_pkg::OUT_TDATA_W-1:0]   m_tdata,
	// [0] tx_valid
	output logic                               m_tuser,
	// configuration writes
	input  logic                               cfg_wr_en,
	input  logic [ptfh_pkg::IDX_W-1:0]         cfg_index,
	input  logic [ptfh_pkg::CFG_W-1:0]         cfg_data
);

	// echo counter bits actually used: the low min(COUNT_WIDTH, 16) bits of the 16-bit field
	localparam int USED_W = (COUNT_WIDTH < ptfh_pkg::ECHO_W) ? COUNT_WIDTH : ptfh_pkg::ECHO_W;

	ptfh_pkg::cfg_t                 cfg_q;

	// stage 1: captured input beat
	logic                           valid_s1;
	logic [ptfh_pkg::CMD_W-1:0]     cmd_s1;
	logic [USED_W-1:0]              count_s1;
	logic                           missing_s1;
	logic [ptfh_pkg::BYTE_W-1:0]    rx_s1;

	logic                           out_valid_q;
	logic                           advance;
	logic                           step_en;
	ptfh_pkg::item_t                item;
	ptfh_pkg::res_t                 res;

	// result register frees when empty or when its beat leaves this cycle
	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign step_en  = valid_s1 && advance;

	// configuration registers; the user must write them only while idle (not enforced here)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.detect_threshold_cm <= ptfh_pkg::THRESH_RST;
			cfg_q.ticks_per_cm        <= ptfh_pkg::TICKS_CM_RST;
			cfg_q.head_wait_ms        <= ptfh_pkg::HEAD_WAIT_RST;
			cfg_q.byte_wait_ms        <= ptfh_pkg::BYTE_WAIT_RST;
			cfg_q.class_show_ms       <= ptfh_pkg::CLASS_SHOW_RST;
			cfg_q.cooldown_ms         <= ptfh_pkg::COOLDOWN_RST;
			cfg_q.blink_wait_ms       <= ptfh_pkg::BLINK_WAIT_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				ptfh_pkg::REG_THRESH:     cfg_q.detect_threshold_cm <= cfg_data[ptfh_pkg::THRESH_W-1:0];
				ptfh_pkg::REG_TICKS_CM:   cfg_q.ticks_per_cm        <= cfg_data[ptfh_pkg::TPC_W-1:0];
				ptfh_pkg::REG_HEAD_WAIT:  cfg_q.head_wait_ms        <= cfg_data;
				ptfh_pkg::REG_BYTE_WAIT:  cfg_q.byte_wait_ms        <= cfg_data;
				ptfh_pkg::REG_CLASS_SHOW: cfg_q.class_show_ms       <= cfg_data;
				ptfh_pkg::REG_COOLDOWN:   cfg_q.cooldown_ms         <= cfg_data;
				ptfh_pkg::REG_BLINK_WAIT: cfg_q.blink_wait_ms       <= cfg_data;
				default: begin
					// index past the register list: ignored
				end
			endcase
		end
	end

	// beat valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	// input payload, loaded on each accepted beat
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1     <= s_tuser;
			count_s1   <= s_tdata[USED_W-1:0];
			missing_s1 <= s_tdata[ptfh_pkg::ECHO_W];
			rx_s1      <= s_tdata[ptfh_pkg::ECHO_W+1 +: ptfh_pkg::BYTE_W];
		end
	end

	assign item.command      = cmd_s1;
	assign item.echo_count   = ptfh_pkg::ECHO_W'(count_s1);
	assign item.echo_missing = missing_s1;
	assign item.rx_byte      = rx_s1;

	// state machine and result register
	ptfh_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.step_en (step_en),
		.item    (item),
		.res     (res)
	);

	assign m_tvalid = out_valid_q;
	assign m_tuser  = res.tx_valid;
	assign m_tdata  = {2'b00, res.want_measure, res.detect_lamp, res.class_lamps, res.tx_byte};

endmodule

FILE: src/ptfh_core.sv
// Handshake state machine: phase, countdown, class and lamp state plus the result register.
module ptfh_core (
	input  logic           clk,
	input  logic           arst_n,
	input  ptfh_pkg::cfg_t cfg,
	input  logic           step_en,
	input  ptfh_pkg::item_t item,
	output ptfh_pkg::res_t res
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_BLINK,
		PH_HEAD,
		PH_CLASS,
		PH_TAIL,
		PH_SHOW,
		PH_COOL
	} phase_t;

	localparam int LIMIT_W = ptfh_pkg::THRESH_W + 1 + ptfh_pkg::TPC_W;

	phase_t                          phase_q, phase_n;
	logic [ptfh_pkg::TIME_W-1:0]     cd_q, cd_n, cd_dec;
	logic [ptfh_pkg::BYTE_W-1:0]     class_q, class_n;
	logic                            det_q, det_n;
	logic [ptfh_pkg::LAMP_W-1:0]     lamp_q, lamp_n;
	ptfh_pkg::res_t                  res_q, res_n;

	logic                            txv;
	logic [ptfh_pkg::BYTE_W-1:0]     txb;
	logic [ptfh_pkg::TPC_W-1:0]      tpc_eff;
	logic [LIMIT_W-1:0]              near_limit;
	logic                            far;
	phase_t                          cool_ph, blink_ph;
	logic                            class_ok;
	logic [1:0]                      cls_idx;
	logic [ptfh_pkg::BYTE_W-1:0]     class_m1;

	function automatic logic [ptfh_pkg::TIME_W-1:0] at_least_one(
		input logic [ptfh_pkg::TIME_W-1:0] v
	);
		return (v == '0) ? ptfh_pkg::TIME_W'(1) : v;
	endfunction

	// floor(count / tpc) > thr  <=>  count >= (thr + 1) * tpc
	assign tpc_eff    = (cfg.ticks_per_cm == '0) ? ptfh_pkg::TPC_W'(1) : cfg.ticks_per_cm;
	assign near_limit = LIMIT_W'({1'b0, cfg.detect_threshold_cm} + 11'd1) * LIMIT_W'(tpc_eff);
	assign far        = item.echo_missing || (LIMIT_W'(item.echo_count) >= near_limit);

	assign cool_ph  = (cfg.cooldown_ms == '0) ? PH_IDLE : PH_COOL;
	assign blink_ph = (cfg.blink_wait_ms == '0) ? PH_IDLE : PH_BLINK;

	assign class_ok = (class_q >= ptfh_pkg::CLASS_MIN) && (class_q <= ptfh_pkg::CLASS_MAX);
	assign class_m1 = class_q - ptfh_pkg::CLASS_MIN;
	assign cls_idx  = class_m1[1:0];
	assign cd_dec   = cd_q - ptfh_pkg::TIME_W'(1);

	always_comb begin
		phase_n = phase_q;
		cd_n    = cd_q;
		class_n = class_q;
		det_n   = det_q;
		lamp_n  = lamp_q;
		txv     = 1'b0;
		txb     = '0;

		unique case (item.command)
			ptfh_pkg::CMD_TICK: begin
				if (phase_q != PH_IDLE) begin
					cd_n = cd_dec;
					if (cd_dec == '0) begin
						unique case (phase_q)
							PH_HEAD, PH_CLASS, PH_TAIL: begin
								txv     = 1'b1;
								txb     = ptfh_pkg::TX_ERROR;
								det_n   = 1'b0;
								phase_n = cool_ph;
								cd_n    = cfg.cooldown_ms;
							end
							PH_SHOW: begin
								lamp_n  = '0;
								txv     = 1'b1;
								txb     = ptfh_pkg::TX_DONE;
								det_n   = 1'b0;
								phase_n = cool_ph;
								cd_n    = cfg.cooldown_ms;
							end
							default: begin
								phase_n = PH_IDLE;
							end
						endcase
					end
				end
			end
			ptfh_pkg::CMD_ECHO: begin
				if (phase_q == PH_IDLE) begin
					if (far) begin
						det_n   = ~det_q;
						phase_n = blink_ph;
						cd_n    = cfg.blink_wait_ms;
					end else begin
						det_n   = 1'b1;
						txv     = 1'b1;
						txb     = ptfh_pkg::TX_READY;
						phase_n = PH_HEAD;
						cd_n    = at_least_one(cfg.head_wait_ms);
					end
				end
			end
			ptfh_pkg::CMD_BYTE: begin
				priority if (phase_q == PH_HEAD) begin
					if (item.rx_byte == ptfh_pkg::BYTE_HEAD) begin
						phase_n = PH_CLASS;
						cd_n    = at_least_one(cfg.byte_wait_ms);
					end else begin
						txv     = 1'b1;
						txb     = ptfh_pkg::TX_ERROR;
						det_n   = 1'b0;
						phase_n = cool_ph;
						cd_n    = cfg.cooldown_ms;
					end
				end else if (phase_q == PH_CLASS) begin
					class_n = item.rx_byte;
					phase_n = PH_TAIL;
					cd_n    = at_least_one(cfg.byte_wait_ms);
				end else if (phase_q == PH_TAIL) begin
					if (item.rx_byte == ptfh_pkg::BYTE_TAIL && class_ok) begin
						lamp_n  = ptfh_pkg::LAMP_W'(1) << cls_idx;
						txv     = 1'b1;
						txb     = ptfh_pkg::TX_ACK;
						phase_n = PH_SHOW;
						cd_n    = at_least_one(cfg.class_show_ms);
					end else begin
						txv     = 1'b1;
						txb     = ptfh_pkg::TX_ERROR;
						det_n   = 1'b0;
						phase_n = cool_ph;
						cd_n    = cfg.cooldown_ms;
					end
				end else begin
					// byte outside the wait phases: dropped
				end
			end
			default: begin
				// unused command code: ignored
			end
		endcase

		res_n.tx_valid     = txv;
		res_n.tx_byte      = txb;
		res_n.class_lamps  = lamp_n;
		res_n.detect_lamp  = det_n;
		res_n.want_measure = (phase_n == PH_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cd_q    <= '0;
			class_q <= '0;
			det_q   <= 1'b0;
			lamp_q  <= '0;
			res_q   <= '{tx_valid: 1'b0, tx_byte: '0, class_lamps: '0,
				detect_lamp: 1'b0, want_measure: 1'b1};
		end else if (step_en) begin
			phase_q <= phase_n;
			cd_q    <= cd_n;
			class_q <= class_n;
			det_q   <= det_n;
			lamp_q  <= lamp_n;
			res_q   <= res_n;
		end
	end

	assign res = res_q;

	// class lamps only lit while showing a class, and at most one
	a_lamp_show: assert property (@(posedge clk) disable iff (!arst_n)
		(lamp_q != '0) |-> (phase_q == PH_SHOW))
		else $error("class lamp lit outside show phase");
	a_lamp_one: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(lamp_q))
		else $error("more than one class lamp lit");
	// every timed phase holds a live countdown
	a_cd_live: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_IDLE) |-> (cd_q != '0))
		else $error("timed phase with zero countdown");
	// result mirrors the state it was taken from
	a_res_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step_en |=> (res_q.want_measure == (phase_q == PH_IDLE)) && (res_q.class_lamps == lamp_q))
		else $error("result out of step with state");
	a_tx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!res_q.tx_valid |-> (res_q.tx_byte == '0))
		else $error("status byte without tx_valid");

endmodule

FILE: sim/proximity_triggered_frame_handshake_test.sv
// Self-checking stream testbench for the proximity-triggered frame handshake controller.
module proximity_triggered_frame_handshake_test;
	import ptfh_pkg::*;

	// command code the block must ignore
	localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
	localparam int HOLD_CYCLES = 300;
	localparam int MAX_REPORTS = 10;

	// controller phases, as the predictor tracks them
	typedef enum logic [2:0] {
		PH_IDLE, PH_BLINK, PH_HEAD, PH_CLASS, PH_TAIL, PH_SHOW, PH_COOL
	} phase_t;

	typedef struct packed {
		phase_t            phase;
		logic [TIME_W-1:0] countdown;
		logic [BYTE_W-1:0] class_code;
		logic              detect_on;
		logic [LAMP_W-1:0] lamps;
	} ctl_state_t;

	// next controller state together with the status beat it produces
	typedef struct packed {
		ctl_state_t st;
		res_t       res;
	} step_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic [CMD_W-1:0]       s_tuser = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tuser;
	logic                   cfg_wr_en = 1'b0;
	logic [IDX_W-1:0]       cfg_index = '0;
	logic [CFG_W-1:0]       cfg_data = '0;

	proximity_triggered_frame_handshake dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// register image shared by predictor and stimulus shaping (only changes when drained)
	cfg_t       ctl_cfg;
	// checker copy of the controller, advanced on accepted input beats
	ctl_state_t ctl_state = '0;
	// stimulus-side copy, advanced as items are queued, used to steer the random part
	ctl_state_t gen_state = '0;

	item_t beats_to_send[$];
	res_t  status_due[$];

	int  send_gap_pct = 0;
	int  recv_gap_pct = 0;
	int  fail_count = 0;
	int  live_items = 0;
	bit  hold_armed = 1'b0;
	logic rx_hold = 1'b0;

	// ---------------------------------------------------------------- predictor

	function automatic logic [TIME_W-1:0] at_least_one(logic [TIME_W-1:0] v);
		return (v == '0) ? TIME_W'(1) : v;
	endfunction

	// a zero-length pause falls straight back to idle
	function automatic ctl_state_t enter_pause(ctl_state_t st, logic [TIME_W-1:0] len,
			phase_t next);
		if (len == '0) begin
			st.phase = PH_IDLE;
			st.countdown = '0;
		end else begin
			st.phase = next;
			st.countdown = len;
		end
		return st;
	endfunction

	// every handshake round ends with the detect lamp dark and a cooldown, if one is set
	function automatic ctl_state_t close_round(ctl_state_t st, cfg_t cfg);
		st.detect_on = 1'b0;
		return enter_pause(st, cfg.cooldown_ms, PH_COOL);
	endfunction

	function automatic step_t step_controller(ctl_state_t st, cfg_t cfg, item_t it);
		step_t             o;
		logic [ECHO_W-1:0] per_cm;
		logic [ECHO_W-1:0] span_cm;
		o.res = '0;
		case (it.command)
			CMD_TICK: begin
				// ticks only matter while something is counting down
				if (st.phase != PH_IDLE) begin
					st.countdown = st.countdown - TIME_W'(1);
					if (st.countdown == '0) begin
						case (st.phase)
							PH_HEAD, PH_CLASS, PH_TAIL: begin
								o.res.tx_valid = 1'b1;
								o.res.tx_byte = TX_ERROR;
								st = close_round(st, cfg);
							end
							PH_SHOW: begin
								st.lamps = '0;
								o.res.tx_valid = 1'b1;
								o.res.tx_byte = TX_DONE;
								st = close_round(st, cfg);
							end
							default: st.phase = PH_IDLE;
						endcase
					end
				end
			end
			CMD_ECHO: begin
				if (st.phase == PH_IDLE) begin
					per_cm = (cfg.ticks_per_cm == '0) ? ECHO_W'(1) : ECHO_W'(cfg.ticks_per_cm);
					span_cm = it.echo_count / per_cm;
					if (it.echo_missing || span_cm > ECHO_W'(cfg.detect_threshold_cm)) begin
						// far or no echo: blink and wait
						st.detect_on = ~st.detect_on;
						st = enter_pause(st, cfg.blink_wait_ms, PH_BLINK);
					end else begin
						st.detect_on = 1'b1;
						o.res.tx_valid = 1'b1;
						o.res.tx_byte = TX_READY;
						st.phase = PH_HEAD;
						st.countdown = at_least_one(cfg.head_wait_ms);
					end
				end
			end
			CMD_BYTE: begin
				case (st.phase)
					PH_HEAD: begin
						if (it.rx_byte == BYTE_HEAD) begin
							st.phase = PH_CLASS;
							st.countdown = at_least_one(cfg.byte_wait_ms);
						end else begin
							o.res.tx_valid = 1'b1;
							o.res.tx_byte = TX_ERROR;
							st = close_round(st, cfg);
						end
					end
					PH_CLASS: begin
						// class is judged only when the tail arrives
						st.class_code = it.rx_byte;
						st.phase = PH_TAIL;
						st.countdown = at_least_one(cfg.byte_wait_ms);
					end
					PH_TAIL: begin
						if (it.rx_byte == BYTE_TAIL && st.class_code >= CLASS_MIN &&
								st.class_code <= CLASS_MAX) begin
							st.lamps = 4'b0001 << (st.class_code - CLASS_MIN);
							o.res.tx_valid = 1'b1;
							o.res.tx_byte = TX_ACK;
							st.phase = PH_SHOW;
							st.countdown = at_least_one(cfg.class_show_ms);
						end else begin
							o.res.tx_valid = 1'b1;
							o.res.tx_byte = TX_ERROR;
							st = close_round(st, cfg);
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
		o.res.class_lamps = st.lamps;
		o.res.detect_lamp = st.detect_on;
		o.res.want_measure = (st.phase == PH_IDLE);
		o.st = st;
		return o;
	endfunction

	// ---------------------------------------------------------------- driver
	// Holds a beat until taken; a new beat is picked only on a free or just-taken slot,
	// so tvalid is assigned once per edge.

	item_t drv_item = '0;
	step_t drv_step;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				drv_step = step_controller(ctl_state, ctl_cfg, drv_item);
				ctl_state = drv_step.st;
				status_due.push_back(drv_step.res);
			end
			if (!s_tvalid || s_tready) begin
				if (beats_to_send.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
					drv_item = beats_to_send.pop_front();
					s_tdata <= {7'd0, drv_item.rx_byte, drv_item.echo_missing,
						drv_item.echo_count};
					s_tuser <= drv_item.command;
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------- monitor

	res_t mon_due;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (status_due.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("unexpected status beat: tdata=%04h tuser=%0d", m_tdata, m_tuser);
				end else begin
					mon_due = status_due.pop_front();
					if (m_tuser !== mon_due.tx_valid || m_tdata[7:0] !== mon_due.tx_byte ||
							m_tdata[11:8] !== mon_due.class_lamps ||
							m_tdata[12] !== mon_due.detect_lamp ||
							m_tdata[13] !== mon_due.want_measure) begin
						fail_count++;
						if (fail_count <= MAX_REPORTS)
							$display("mismatch exp tx=%0d byte=%02h lamps=%h det=%0d idle=%0d | got tx=%0d byte=%02h lamps=%h det=%0d idle=%0d",
								mon_due.tx_valid, mon_due.tx_byte, mon_due.class_lamps,
								mon_due.detect_lamp, mon_due.want_measure, m_tuser,
								m_tdata[7:0], m_tdata[11:8], m_tdata[12], m_tdata[13]);
					end
				end
			end
			m_tready <= !rx_hold && ($urandom_range(99) >= recv_gap_pct);
		end
	end

	// long receiver stall: the block fills up and must back-pressure its input
	initial begin
		wait (hold_armed);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	// ---------------------------------------------------------------- stimulus

	task automatic offer(input logic [CMD_W-1:0] cmd, input logic [ECHO_W-1:0] count,
			input logic miss, input logic [BYTE_W-1:0] rx);
		item_t it;
		step_t nxt;
		it.command = cmd;
		it.echo_count = count;
		it.echo_missing = miss;
		it.rx_byte = rx;
		// only items that move the controller count toward the random budget
		if ((cmd == CMD_TICK && gen_state.phase != PH_IDLE) ||
				(cmd == CMD_ECHO && gen_state.phase == PH_IDLE) ||
				(cmd == CMD_BYTE && (gen_state.phase == PH_HEAD ||
				gen_state.phase == PH_CLASS || gen_state.phase == PH_TAIL)))
			live_items++;
		nxt = step_controller(gen_state, ctl_cfg, it);
		gen_state = nxt.st;
		beats_to_send.push_back(it);
	endtask

	// unused fields of a tick carry noise
	task automatic push_tick();
		offer(CMD_TICK, ECHO_W'($urandom), 1'($urandom), BYTE_W'($urandom));
	endtask

	task automatic settle();
		while (gen_state.phase != PH_IDLE)
			push_tick();
	endtask

	// Mostly well-formed rounds with random content; some noise, bad bytes and timeouts.
	task automatic gen_random_item();
		int unsigned       pick;
		int unsigned       sub;
		int unsigned       edge_cnt;
		int unsigned       near_hi;
		logic [CMD_W-1:0]  cmd;
		logic [ECHO_W-1:0] count;
		logic              miss;
		logic [BYTE_W-1:0] rx;
		pick = $urandom_range(99);
		sub = $urandom_range(99);
		cmd = CMD_TICK;
		count = ECHO_W'($urandom);
		miss = 1'($urandom);
		rx = BYTE_W'($urandom);
		// first echo count that reads as far
		edge_cnt = (int'(ctl_cfg.detect_threshold_cm) + 1) *
			((ctl_cfg.ticks_per_cm == '0) ? 1 : int'(ctl_cfg.ticks_per_cm));
		near_hi = (edge_cnt > 65536) ? 65535 : edge_cnt - 1;
		if (pick < 3) begin
			cmd = CMD_SPARE;
		end else begin
			case (gen_state.phase)
				PH_IDLE: begin
					if (pick < 7) begin
						cmd = CMD_TICK;
					end else if (pick < 11) begin
						cmd = CMD_BYTE;
					end else begin
						cmd = CMD_ECHO;
						miss = 1'b0;
						if (sub < 65)
							count = ($urandom_range(2) == 0) ? ECHO_W'(near_hi) :
								ECHO_W'($urandom_range(0, near_hi));
						else if (sub < 85 && edge_cnt <= 65535)
							count = ($urandom_range(2) == 0) ? ECHO_W'(edge_cnt) :
								ECHO_W'($urandom_range(edge_cnt, 65535));
						else
							miss = 1'b1;
					end
				end
				PH_HEAD, PH_CLASS, PH_TAIL: begin
					if (pick < 20) begin
						cmd = CMD_TICK;
					end else if (pick < 25) begin
						cmd = CMD_ECHO;
					end else begin
						cmd = CMD_BYTE;
						if (gen_state.phase == PH_HEAD && sub < 90)
							rx = BYTE_HEAD;
						else if (gen_state.phase == PH_CLASS && sub < 85)
							rx = BYTE_W'($urandom_range(CLASS_MIN, CLASS_MAX));
						else if (gen_state.phase == PH_TAIL && sub < 90)
							rx = BYTE_TAIL;
					end
				end
				default: begin
					if (pick < 90)
						cmd = CMD_TICK;
					else if (pick < 95)
						cmd = CMD_BYTE;
					else
						cmd = CMD_ECHO;
				end
			endcase
		end
		offer(cmd, count, miss, rx);
	endtask

	task automatic run_random(input int n);
		live_items = 0;
		while (live_items < n)
			gen_random_item();
		settle();
	endtask

	task automatic put_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_THRESH:     ctl_cfg.detect_threshold_cm = val[THRESH_W-1:0];
			REG_TICKS_CM:   ctl_cfg.ticks_per_cm = val[TPC_W-1:0];
			REG_HEAD_WAIT:  ctl_cfg.head_wait_ms = val;
			REG_BYTE_WAIT:  ctl_cfg.byte_wait_ms = val;
			REG_CLASS_SHOW: ctl_cfg.class_show_ms = val;
			REG_COOLDOWN:   ctl_cfg.cooldown_ms = val;
			REG_BLINK_WAIT: ctl_cfg.blink_wait_ms = val;
			default: ;
		endcase
	endtask

	task automatic apply_settings(input int thr, input int per_cm, input int head_w,
			input int byte_w, input int show, input int cool, input int blink);
		put_reg(REG_THRESH, CFG_W'(thr));
		put_reg(REG_TICKS_CM, CFG_W'(per_cm));
		put_reg(REG_HEAD_WAIT, CFG_W'(head_w));
		put_reg(REG_BYTE_WAIT, CFG_W'(byte_w));
		put_reg(REG_CLASS_SHOW, CFG_W'(show));
		put_reg(REG_COOLDOWN, CFG_W'(cool));
		put_reg(REG_BLINK_WAIT, CFG_W'(blink));
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic set_gaps(input int send_pct, input int recv_pct);
		send_gap_pct <= send_pct;
		recv_gap_pct <= recv_pct;
	endtask

	// every queued beat sent and every status beat seen, plus pipeline slack
	task automatic wait_drained();
		while (beats_to_send.size() != 0 || s_tvalid || status_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		ctl_cfg.detect_threshold_cm = THRESH_RST;
		ctl_cfg.ticks_per_cm = TICKS_CM_RST;
		ctl_cfg.head_wait_ms = HEAD_WAIT_RST;
		ctl_cfg.byte_wait_ms = BYTE_WAIT_RST;
		ctl_cfg.class_show_ms = CLASS_SHOW_RST;
		ctl_cfg.cooldown_ms = COOLDOWN_RST;
		ctl_cfg.blink_wait_ms = BLINK_WAIT_RST;
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// directed: threshold 20 cm at 10 counts/cm, short waits
		set_gaps(25, 55);
		apply_settings(20, 10, 3, 2, 2, 1, 1);
		push_tick();                                 // tick in idle, ignored
		offer(CMD_SPARE, 16'hFFFF, 1'b1, 8'hFF);     // unused command, all bits high
		offer(CMD_BYTE, 16'd0, 1'b0, BYTE_HEAD);     // byte outside the waits, dropped
		offer(CMD_ECHO, 16'd0, 1'b1, 8'd0);          // missing echo reads far
		settle();
		offer(CMD_ECHO, 16'd209, 1'b0, 8'd0);        // exactly at threshold: near
		offer(CMD_ECHO, 16'd0, 1'b0, 8'd0);          // echo while waiting, ignored
		offer(CMD_BYTE, 16'd0, 1'b0, 8'h00);         // wrong head
		settle();
		offer(CMD_ECHO, 16'd210, 1'b0, 8'd0);        // one cm past threshold: far
		settle();
		offer(CMD_ECHO, 16'd0, 1'b0, 8'd0);
		repeat (3) push_tick();                      // head wait runs out
		settle();
		offer(CMD_ECHO, 16'd0, 1'b0, 8'd0);
		offer(CMD_BYTE, 16'd0, 1'b0, BYTE_HEAD);
		offer(CMD_BYTE, 16'd0, 1'b0, 8'h00);         // class out of range
		offer(CMD_BYTE, 16'd0, 1'b0, BYTE_TAIL);
		settle();
		offer(CMD_ECHO, 16'd0, 1'b0, 8'd0);
		offer(CMD_BYTE, 16'd0, 1'b0, BYTE_HEAD);
		offer(CMD_BYTE, 16'd0, 1'b0, CLASS_MAX);
		offer(CMD_BYTE, 16'd0, 1'b0, BYTE_TAIL);     // good frame
		offer(CMD_BYTE, 16'd0, 1'b0, BYTE_HEAD);     // during class show, dropped
		settle();
		wait_drained();

		// default distance settings, short waits; receiver stall lands in this phase
		apply_settings(15, 54, 4, 3, 5, 2, 3);
		hold_armed = 1'b1;
		run_random(150);
		wait_drained();

		// maximum threshold and scale, zero waits and pauses
		apply_settings(1023, 255, 0, 0, 0, 0, 0);
		run_random(150);
		wait_drained();

		// zero threshold and zero scale; only a zero count reads as near
		set_gaps(55, 25);
		apply_settings(0, 0, 6, 5, 3, 3, 2);
		run_random(150);
		wait_drained();

		apply_settings(100, 1, 2, 1, 1, 0, 1);
		run_random(150);
		wait_drained();

		set_gaps(0, 0);
		apply_settings(512, 128, 8, 6, 4, 1, 0);
		run_random(150);
		wait_drained();

		// longest waits: one good round, then it stays in the class show
		apply_settings(1023, 1, 65535, 65535, 65535, 65535, 65535);
		offer(CMD_ECHO, 16'd0, 1'b0, 8'd0);
		offer(CMD_BYTE, 16'd0, 1'b0, BYTE_HEAD);
		offer(CMD_BYTE, 16'd0, 1'b0, CLASS_MIN + 8'd1);
		offer(CMD_BYTE, 16'd0, 1'b0, BYTE_TAIL);
		repeat (20) gen_random_item();
		wait_drained();

		if (status_due.size() != 0) begin
			$display("%0d status beats never arrived", status_due.size());
			fail_count += status_due.size();
		end
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#500000;
		$display("tb: failure");
		$finish;
	end

endmodule
